@@ rtl/core/rc4_pkg.sv @@
package rc4_pkg;

  localparam int KEY_DEPTH = 256;
  localparam int KEY_AW    = $clog2(KEY_DEPTH);
  localparam int LEN_W     = 9;

  localparam logic [LEN_W-1:0] KEY_LEN_RESET = LEN_W'(16);
  localparam logic [LEN_W-1:0] KEY_LEN_MAX   = LEN_W'(KEY_DEPTH);

  localparam logic [1:0] OP_LOAD_KEY = 2'd0;
  localparam logic [1:0] OP_SCHEDULE = 2'd1;
  localparam logic [1:0] OP_CRYPT    = 2'd2;

  typedef logic [7:0] byte_t;

endpackage

@@ rtl/core/rc4_stream_cipher_top.sv @@
// RC4 byte stream cipher. Every input transfer is accepted only while the core is idle.
// A key byte load (tuser 0) writes key_byte at key_index. A key schedule (tuser 1) clears the
// permutation to identity on acceptance and then runs 256 steps, each of them a read of
// S[n] and the key byte, a read of S[j], and two writes, since the permutation memory
// has one read and one write port.
// A data byte (tuser 2) reads S[i], reads S[j], makes two swap writes and issues the
// keystream read with the second write; the next transfer is taken only once the result
// is in the output register. The output register holds the result, and a
// new byte is accepted while it waits; the following result waits until it is taken.
// The user must write the key length through the cfg port only while idle; the core does not enforce it.
module rc4_stream_cipher_top
  import rc4_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [23:0]      s_axis_tdata,   // key_index[7:0], key_byte[15:8], data_byte[23:16]
  input  logic [1:0]       s_axis_tuser,   // opcode[1:0]
  input  logic             s_axis_tlast,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // out_byte[7:0]
  output logic             m_axis_tlast,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_data
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_KS_RD   = 4'd1;
  localparam logic [3:0] ST_KS_CALC = 4'd2;
  localparam logic [3:0] ST_KS_WR1  = 4'd3;
  localparam logic [3:0] ST_KS_WR2  = 4'd4;
  localparam logic [3:0] ST_CR_RD   = 4'd5;
  localparam logic [3:0] ST_CR_CALC = 4'd6;
  localparam logic [3:0] ST_CR_WR1  = 4'd7;
  localparam logic [3:0] ST_CR_WR2  = 4'd8;
  localparam logic [3:0] ST_CR_OUT  = 4'd9;

  logic [3:0]        state;
  logic [3:0]        state_next;
  logic [LEN_W-1:0]  key_length;
  logic [LEN_W-1:0]  len_eff;
  byte_t             idx_i;
  byte_t             idx_j;
  byte_t             step_n;
  logic [KEY_AW-1:0] key_pos;
  byte_t             sa;
  byte_t             sb;
  byte_t             data_q;
  logic              mend_q;
  logic              fwd_j;

  byte_t             perm_mem [256];
  logic [255:0]      perm_vld;
  byte_t             perm_raddr;
  byte_t             perm_raddr_q;
  byte_t             perm_rdata;
  logic              perm_rvld;
  byte_t             perm_val;
  logic              perm_we;
  byte_t             perm_waddr;
  byte_t             perm_wdata;
  logic              perm_clear;

  byte_t             key_mem [KEY_DEPTH];
  byte_t             key_rdata;
  logic              key_we;

  logic              in_xfer;
  logic              out_free;
  byte_t             j_sched;
  byte_t             j_crypt;
  logic [LEN_W-1:0]  key_pos_inc;

  assign in_xfer    = s_axis_tvalid && s_axis_tready;
  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign cfg_ready  = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);

  assign perm_val   = perm_rvld ? perm_rdata : perm_raddr_q;
  assign j_sched    = idx_j + perm_val + key_rdata;
  assign j_crypt    = idx_j + perm_val;
  assign key_pos_inc = LEN_W'(key_pos) + LEN_W'(1);

  always_comb begin
    if (key_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (key_length > KEY_LEN_MAX) begin
      len_eff = KEY_LEN_MAX;
    end else begin
      len_eff = key_length;
    end
  end

  assign perm_clear = in_xfer && (s_axis_tuser == OP_SCHEDULE);
  assign key_we     = in_xfer && (s_axis_tuser == OP_LOAD_KEY)
                      && ({1'b0, s_axis_tdata[7:0]} < KEY_LEN_MAX);

  always_comb begin
    state_next = state;
    perm_raddr = perm_raddr_q;
    perm_we    = 1'b0;
    perm_waddr = idx_i;
    perm_wdata = sb;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          case (s_axis_tuser)
            OP_SCHEDULE: state_next = ST_KS_RD;
            OP_CRYPT:    state_next = ST_CR_RD;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_KS_RD: begin
        perm_raddr = step_n;
        state_next = ST_KS_CALC;
      end
      ST_KS_CALC: begin
        perm_raddr = j_sched;
        state_next = ST_KS_WR1;
      end
      ST_KS_WR1: begin
        perm_we    = 1'b1;
        perm_waddr = step_n;
        perm_wdata = perm_val;
        state_next = ST_KS_WR2;
      end
      ST_KS_WR2: begin
        perm_we    = 1'b1;
        perm_waddr = idx_j;
        perm_wdata = sa;
        state_next = (step_n == 8'hFF) ? ST_IDLE : ST_KS_RD;
      end
      ST_CR_RD: begin
        perm_raddr = idx_i;
        state_next = ST_CR_CALC;
      end
      ST_CR_CALC: begin
        perm_raddr = j_crypt;
        state_next = ST_CR_WR1;
      end
      ST_CR_WR1: begin
        perm_we    = 1'b1;
        perm_waddr = idx_i;
        perm_wdata = perm_val;
        state_next = ST_CR_WR2;
      end
      ST_CR_WR2: begin
        perm_we    = 1'b1;
        perm_waddr = idx_j;
        perm_wdata = sa;
        perm_raddr = sa + sb;
        state_next = ST_CR_OUT;
      end
      ST_CR_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (perm_we) begin
      perm_mem[perm_waddr] <= perm_wdata;
    end
    perm_rdata   <= perm_mem[perm_raddr];
    perm_raddr_q <= perm_raddr;
  end

  always_ff @(posedge clk) begin
    if (rst || perm_clear) begin
      perm_vld  <= '0;
      perm_rvld <= 1'b0;
    end else begin
      perm_rvld <= perm_vld[perm_raddr];
      if (perm_we) begin
        perm_vld[perm_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[s_axis_tdata[KEY_AW-1:0]] <= s_axis_tdata[15:8];
    end
    key_rdata <= key_mem[key_pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      key_length    <= KEY_LEN_RESET;
      idx_i         <= '0;
      idx_j         <= '0;
      step_n        <= '0;
      key_pos       <= '0;
      fwd_j         <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        key_length <= cfg_data;
      end
      if ((state == ST_CR_OUT) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            case (s_axis_tuser)
              OP_SCHEDULE: begin
                idx_j   <= '0;
                step_n  <= '0;
                key_pos <= '0;
              end
              OP_CRYPT: idx_i <= idx_i + 8'd1;
              default: ;
            endcase
          end
        end
        ST_KS_CALC: idx_j <= j_sched;
        ST_KS_WR2: begin
          step_n  <= step_n + 8'd1;
          key_pos <= (key_pos_inc >= len_eff) ? '0 : key_pos + KEY_AW'(1);
          if (step_n == 8'hFF) begin
            idx_i <= '0;
            idx_j <= '0;
          end
        end
        ST_CR_CALC: idx_j <= j_crypt;
        ST_CR_WR2:  fwd_j <= ((sa + sb) == idx_j);
        ST_CR_OUT:  fwd_j <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      data_q <= s_axis_tdata[23:16];
      mend_q <= s_axis_tlast;
    end
    if ((state == ST_KS_CALC) || (state == ST_CR_CALC)) begin
      sa <= perm_val;
    end
    if ((state == ST_KS_WR1) || (state == ST_CR_WR1)) begin
      sb <= perm_val;
    end
    if ((state == ST_CR_OUT) && out_free) begin
      m_axis_tdata <= data_q ^ (fwd_j ? sa : perm_val);
      m_axis_tlast <= mend_q;
    end
  end

endmodule

@@ sim/rc4_stream_cipher_top_tb.sv @@
`timescale 1ns / 1ps

module rc4_stream_cipher_top_tb;
  import rc4_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 1100;
  localparam int HOLD_CYCLES   = 300;

  typedef struct packed {
    logic [1:0] op;
    byte_t      kidx;
    byte_t      kval;
    byte_t      din;
    logic       last;
  } cipher_item_t;

  typedef struct packed {
    byte_t dout;
    logic  last;
  } keystream_out_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [23:0]      s_axis_tdata = '0;
  logic [1:0]       s_axis_tuser = '0;
  logic             s_axis_tlast = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [7:0]       m_axis_tdata;
  logic             m_axis_tlast;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_data = '0;

  rc4_stream_cipher_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // cipher state as predicted
  byte_t            sbox_mdl [256];
  byte_t            key_mdl  [256];
  byte_t            idx_i = '0;
  byte_t            idx_j = '0;
  logic [LEN_W-1:0] key_len_mdl = KEY_LEN_RESET;

  cipher_item_t   pending_items [$];
  keystream_out_t expected_bytes [$];
  cipher_item_t   drv_item;
  bit             key_written [256];

  bit          in_taken = 1'b0;
  bit          cfg_taken = 1'b0;
  bit          in_idle_on = 1'b1;
  bit          out_idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  int unsigned hold_cnt = 0;

  int unsigned mismatches = 0;
  int unsigned stim_items = 0;
  int unsigned bytes_out = 0;
  int unsigned schedules_run = 0;
  int unsigned keys_loaded = 0;
  int unsigned cfg_writes = 0;

  function automatic int unsigned effective_len(input logic [LEN_W-1:0] len);
    if (len == 0) return 1;
    if (int'(len) > KEY_DEPTH) return KEY_DEPTH;
    return int'(len);
  endfunction

  task automatic cipher_apply(input cipher_item_t it);
    byte_t          t;
    byte_t          a;
    byte_t          j;
    int unsigned    len;
    int unsigned    k;
    keystream_out_t r;
    case (it.op)
      OP_LOAD_KEY: begin
        if (int'(it.kidx) < KEY_DEPTH) key_mdl[it.kidx] = it.kval;
        keys_loaded++;
      end
      OP_SCHEDULE: begin
        len = effective_len(key_len_mdl);
        for (int n = 0; n < 256; n++) sbox_mdl[n] = byte_t'(n);
        j = '0;
        k = 0;
        for (int n = 0; n < 256; n++) begin
          j = j + sbox_mdl[n] + key_mdl[k];
          t = sbox_mdl[n];
          sbox_mdl[n] = sbox_mdl[j];
          sbox_mdl[j] = t;
          k++;
          if (k >= len) k = 0;
        end
        idx_i = '0;
        idx_j = '0;
        schedules_run++;
      end
      OP_CRYPT: begin
        idx_i = idx_i + 8'd1;
        idx_j = idx_j + sbox_mdl[idx_i];
        t = sbox_mdl[idx_i];
        sbox_mdl[idx_i] = sbox_mdl[idx_j];
        sbox_mdl[idx_j] = t;
        a = sbox_mdl[idx_i] + sbox_mdl[idx_j];
        r.dout = it.din ^ sbox_mdl[a];
        r.last = it.last;
        expected_bytes.push_back(r);
      end
      default: ;
    endcase
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // input side: sample transfers, drive on the falling edge
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      cipher_apply(drv_item);
      in_taken = 1'b1;
    end
    if (!rst && cfg_valid && cfg_ready) begin
      key_len_mdl = cfg_data;
      cfg_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst && (!s_axis_tvalid || in_taken)) begin
      in_taken = 1'b0;
      if (in_gap != 0) begin
        in_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        drv_item = pending_items.pop_front();
        s_axis_tdata  <= {drv_item.din, drv_item.kval, drv_item.kidx};
        s_axis_tuser  <= drv_item.op;
        s_axis_tlast  <= drv_item.last;
        s_axis_tvalid <= 1'b1;
        in_gap = in_idle_on ? pick_gap() : 0;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output side
  always @(negedge clk) begin
    if (hold_req && m_axis_tvalid) begin
      hold_req = 1'b0;
      hold_cnt = HOLD_CYCLES;
    end
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else if (out_gap != 0) begin
      out_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      out_gap = out_idle_on ? pick_gap() : 0;
    end
  end

  always @(posedge clk) begin
    keystream_out_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      bytes_out++;
      if (expected_bytes.size() == 0) begin
        $error("unexpected output transfer: out_byte %02h", m_axis_tdata);
        mismatches++;
      end else begin
        e = expected_bytes.pop_front();
        if (m_axis_tdata !== e.dout) begin
          $error("out_byte: expected %02h, got %02h", e.dout, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tlast !== e.last) begin
          $error("message_end_out: expected %0b, got %0b", e.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  function automatic byte_t rnd8();
    return byte_t'($urandom);
  endfunction

  function automatic cipher_item_t make_item(input logic [1:0] op, input byte_t kidx,
                                             input byte_t kval, input byte_t din,
                                             input logic last);
    cipher_item_t it;
    it.op   = op;
    it.kidx = kidx;
    it.kval = kval;
    it.din  = din;
    it.last = last;
    return it;
  endfunction

  task automatic queue_item(input cipher_item_t it);
    pending_items.push_back(it);
    if (it.op != OP_UNUSED) stim_items++;
    if (it.op == OP_LOAD_KEY) key_written[it.kidx] = 1'b1;
  endtask

  task automatic queue_message(input int unsigned len);
    logic last_flag;
    for (int unsigned b = 0; b < len; b++) begin
      if ($urandom_range(0, 24) == 0)
        queue_item(make_item(OP_UNUSED, rnd8(), rnd8(), rnd8(), 1'($urandom)));
      if ($urandom_range(0, 29) == 0)
        queue_item(make_item(OP_LOAD_KEY, rnd8(), rnd8(), rnd8(), 1'($urandom)));
      last_flag = (b == len - 1) ? 1'b1 : ($urandom_range(0, 14) == 0);
      queue_item(make_item(OP_CRYPT, rnd8(), rnd8(), rnd8(), last_flag));
    end
  endtask

  task automatic drain_and_settle();
    do @(posedge clk);
    while (pending_items.size() != 0 || s_axis_tvalid || expected_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_key_length(input logic [LEN_W-1:0] len);
    drain_and_settle();
    @(negedge clk);
    cfg_data  <= len;
    cfg_valid <= 1'b1;
    do @(negedge clk);
    while (!cfg_taken);
    cfg_valid <= 1'b0;
    cfg_taken = 1'b0;
    cfg_writes++;
  endtask

  initial begin
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] len_list [7];
    int unsigned      eff;
    int unsigned      msgs;
    bit               pressure;

    len_list = '{9'd0, 9'd1, 9'd256, 9'd511, 9'd2, 9'd255, 9'd257};
    for (int n = 0; n < 256; n++) sbox_mdl[n] = byte_t'(n);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // identity permutation, ignored opcode, key at the reset length
    queue_item(make_item(OP_CRYPT, rnd8(), rnd8(), 8'h00, 1'b0));
    queue_item(make_item(OP_CRYPT, rnd8(), rnd8(), 8'hFF, 1'b1));
    queue_item(make_item(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    queue_item(make_item(OP_LOAD_KEY, 8'hFF, 8'hFF, rnd8(), 1'b0));
    for (int k = 0; k < 16; k++)
      queue_item(make_item(OP_LOAD_KEY, byte_t'(k),
                           (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : rnd8(), rnd8(), 1'b0));
    queue_item(make_item(OP_SCHEDULE, rnd8(), rnd8(), rnd8(), 1'b0));
    queue_item(make_item(OP_CRYPT, rnd8(), rnd8(), 8'hFF, 1'b0));
    queue_item(make_item(OP_CRYPT, rnd8(), rnd8(), 8'h00, 1'b0));
    queue_item(make_item(OP_UNUSED, 8'h00, 8'h00, 8'h00, 1'b0));
    queue_item(make_item(OP_CRYPT, rnd8(), rnd8(), 8'h5A, 1'b1));

    for (int p = 0; stim_items < 1450; p++) begin
      if (p < 7)
        len = len_list[p];
      else if ($urandom_range(0, 9) < 7)
        len = LEN_W'($urandom_range(1, 32));
      else
        len = LEN_W'($urandom_range(0, 511));
      set_key_length(len);
      eff = effective_len(len);
      pressure = (p == 3);
      in_idle_on  = pressure ? 1'b0 : ($urandom_range(0, 3) != 0);
      out_idle_on = $urandom_range(0, 3) != 0;

      for (int unsigned k = 0; k < eff; k++) begin
        if ($urandom_range(0, 19) == 0)
          queue_item(make_item(OP_UNUSED, rnd8(), rnd8(), rnd8(), 1'($urandom)));
        if (!key_written[k] || (eff <= 32 && $urandom_range(0, 2) != 0))
          queue_item(make_item(OP_LOAD_KEY, byte_t'(k), rnd8(), rnd8(), 1'($urandom)));
      end
      repeat ($urandom_range(0, 3))
        queue_item(make_item(OP_LOAD_KEY, rnd8(), rnd8(), rnd8(), 1'($urandom)));
      // now and then keep the old permutation running
      if (pressure || $urandom_range(0, 7) != 0)
        queue_item(make_item(OP_SCHEDULE, rnd8(), rnd8(), rnd8(), 1'($urandom)));
      if (pressure) hold_req = 1'b1;

      msgs = $urandom_range(1, 3);
      for (int unsigned m = 0; m < msgs; m++) begin
        queue_message(pressure ? 120 : $urandom_range(1, 40));
        if ($urandom_range(0, 7) == 0)
          queue_item(make_item(OP_SCHEDULE, rnd8(), rnd8(), rnd8(), 1'($urandom)));
      end
    end

    drain_and_settle();
    if (expected_bytes.size() != 0) begin
      $error("%0d expected output bytes never arrived", expected_bytes.size());
      mismatches++;
    end
    $display("Run covered %0d output bytes, %0d key schedules, %0d key byte loads",
             bytes_out, schedules_run, keys_loaded);
    $display("over %0d key length settings, with random gaps and a long output stall",
             cfg_writes + 1);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/rc4_pkg.sv
rtl/core/rc4_stream_cipher_top.sv
sim/rc4_stream_cipher_top_tb.sv
